// ----- hw/rtl/c8eu_pkg.sv -----
// package for the chip-8 register execute unit
// shared widths, opcode group codes, status codes and the write-back struct
// no dependencies
`default_nettype none

package c8eu_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

   localparam int NUM_VREGS = 16;
   localparam logic [3:0] VF_IDX = 4'hF;

   // opcode groups, top nibble
   localparam logic [3:0] GRP_SYS   = 4'h0;
   localparam logic [3:0] GRP_JP    = 4'h1;
   localparam logic [3:0] GRP_CALL  = 4'h2;
   localparam logic [3:0] GRP_SE    = 4'h3;
   localparam logic [3:0] GRP_SNE   = 4'h4;
   localparam logic [3:0] GRP_SER   = 4'h5;
   localparam logic [3:0] GRP_LD    = 4'h6;
   localparam logic [3:0] GRP_ADD   = 4'h7;
   localparam logic [3:0] GRP_ALU   = 4'h8;
   localparam logic [3:0] GRP_SNER  = 4'h9;
   localparam logic [3:0] GRP_LDI   = 4'hA;
   localparam logic [3:0] GRP_JPV0  = 4'hB;
   localparam logic [3:0] GRP_RND   = 4'hC;
   localparam logic [3:0] GRP_MISC  = 4'hF;

   localparam logic [15:0] OPC_CLS = 16'h00E0;
   localparam logic [15:0] OPC_RET = 16'h00EE;

   // 8xyn sub-codes
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // fxnn sub-codes
   localparam logic [7:0] FX_GET_DT  = 8'h07;
   localparam logic [7:0] FX_SET_DT  = 8'h15;
   localparam logic [7:0] FX_SET_ST  = 8'h18;
   localparam logic [7:0] FX_ADD_I   = 8'h1E;
   localparam logic [7:0] FX_FONT    = 8'h29;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNHANDLED = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic       wx;
      logic [3:0] x;
      logic [7:0] valx;
      logic       wf;
      logic       valf;
   } wb_type;

endpackage

`default_nettype wire

// ----- hw/rtl/c8eu_vregs.sv -----
// general register file v0-ve as a synchronous memory, vf in a flop
// two registered read ports with write-to-read forwarding; uses c8eu_pkg
`default_nettype none

module c8eu_vregs import c8eu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rd_en,
   input  wire logic [3:0] rd_addr_a,
   input  wire logic [3:0] rd_addr_b,
   input  wire wb_type     wb,
   output logic      [7:0] rd_data_a,
   output logic      [7:0] rd_data_b
);

   logic [7:0]           mem [NUM_VREGS];
   logic [NUM_VREGS-1:0] vld_ff;
   logic [7:0]           vf_ff;

   logic [3:0] addr_a_ff, addr_b_ff;
   logic [7:0] data_a_ff, data_b_ff;
   logic       zero_a_ff, zero_b_ff;
   logic       hit_a_ff, hit_b_ff;
   logic [7:0] fwd_ff;
   logic       wr_mem;

   assign wr_mem = wb.wx && (wb.x != VF_IDX);

   always_ff @(posedge clock) begin
      if (wr_mem) begin
         mem[wb.x] <= wb.valx;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vf_ff     <= '0;
         addr_a_ff <= '0;
         addr_b_ff <= '0;
         zero_a_ff <= 1'b1;
         zero_b_ff <= 1'b1;
         hit_a_ff  <= 1'b0;
         hit_b_ff  <= 1'b0;
         fwd_ff    <= '0;
      end else begin
         if (wr_mem) begin
            vld_ff[wb.x] <= 1'b1;
         end
         // flag has priority over vx, so it wins when x is vf
         if (wb.wf) begin
            vf_ff <= {7'd0, wb.valf};
         end else if (wb.wx && (wb.x == VF_IDX)) begin
            vf_ff <= wb.valx;
         end
         if (rd_en) begin
            addr_a_ff <= rd_addr_a;
            addr_b_ff <= rd_addr_b;
            zero_a_ff <= !vld_ff[rd_addr_a];
            zero_b_ff <= !vld_ff[rd_addr_b];
            // same-edge write is not seen by the memory read
            hit_a_ff  <= wr_mem && (wb.x == rd_addr_a);
            hit_b_ff  <= wr_mem && (wb.x == rd_addr_b);
            fwd_ff    <= wb.valx;
         end
      end
   end

   always_comb begin
      priority if (addr_a_ff == VF_IDX) rd_data_a = vf_ff;
      else if (hit_a_ff)                rd_data_a = fwd_ff;
      else if (zero_a_ff)               rd_data_a = '0;
      else                              rd_data_a = data_a_ff;

      priority if (addr_b_ff == VF_IDX) rd_data_b = vf_ff;
      else if (hit_b_ff)                rd_data_b = fwd_ff;
      else if (zero_b_ff)               rd_data_b = '0;
      else                              rd_data_b = data_b_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/chip8_register_execute_unit_top.sv -----
// chip-8 register execute unit, top level
// depends on c8eu_pkg and c8eu_vregs
//
// Executes one fetched chip-8 opcode per item and returns one result per item.
// Sustained rate is one item per clock while results are taken: an item is
// accepted, its register and return-stack reads are issued at once, it
// executes in the next cycle and at the end of that cycle commits its state
// and loads the output register, which raises rsp_valid. The next item is
// taken while a result still waits; a stall on the result side holds the
// execute stage and then drops req_ready. req_ready is low during reset. V0-VE
// and the return stack live in synchronous memories with registered reads; a
// write by the executing item is forwarded to the reads of the item accepted
// on the same edge. No clearing pass is needed after reset.
`default_nettype none

module chip8_register_execute_unit_top import c8eu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_instruction_word,
   input  wire logic [7:0]  req_random_byte,
   input  wire logic        req_timer_tick,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [11:0] rsp_next_pc,
   output logic             rsp_vx_write,
   output logic      [3:0]  rsp_vx_index,
   output logic      [7:0]  rsp_vx_value,
   output logic             rsp_vf_write,
   output logic             rsp_vf_value,
   output logic      [15:0] rsp_index_value,
   output logic             rsp_clear_screen,
   output logic             rsp_sound_on,
   output logic      [1:0]  rsp_status
);

   // architectural state
   logic [11:0]      pc_ff;
   logic [15:0]      idx_ff, idx_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [7:0]       dt_ff, dt_in, st_ff, st_in;
   logic [11:0]      stack_mem [STACK_DEPTH];

   // execute stage
   logic        s1_valid_ff;
   logic [15:0] s1_op_ff;
   logic [7:0]  s1_rnd_ff;
   logic        s1_tick_ff;
   logic [11:0] stk_data_ff, stk_fwd_ff;
   logic        stk_hit_ff;

   // result register
   logic        rsp_valid_ff;
   logic [11:0] next_pc_ff;
   logic        vx_write_ff, vf_write_ff, vf_value_ff, cls_ff, sound_ff;
   logic [3:0]  vx_index_ff;
   logic [7:0]  vx_value_ff;
   logic [15:0] index_value_ff;
   status_type  status_ff;

   logic        accept, fire;
   logic [3:0]  rd_addr_a;
   logic [7:0]  vx, vy;
   wb_type      wb, wb_gated;

   logic [3:0]       x, n;
   logic [7:0]       nn;
   logic [11:0]      nnn, pc2, pc4, next_pc, stk_top;
   logic [8:0]       sum;
   logic [7:0]       dt_tick, st_tick;
   logic             cls, push;
   status_type       status;
   logic [LVL_W-1:0] lvl_rd, lvl_cur;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || fire);
   assign accept    = req_valid && req_ready;

   // bnnn reads v0 on port a in place of vx
   assign rd_addr_a = (req_instruction_word[15:12] == GRP_JPV0) ? 4'd0
                                                               : req_instruction_word[11:8];

   assign wb_gated = fire ? wb : '0;

   c8eu_vregs u_vregs (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (req_instruction_word[7:4]),
      .wb        (wb_gated),
      .rd_data_a (vx),
      .rd_data_b (vy)
   );

   assign stk_top = stk_hit_ff ? stk_fwd_ff : stk_data_ff;

   // execute
   always_comb begin
      x       = s1_op_ff[11:8];
      n       = s1_op_ff[3:0];
      nn      = s1_op_ff[7:0];
      nnn     = s1_op_ff[11:0];
      pc2     = pc_ff + 12'd2;
      pc4     = pc_ff + 12'd4;
      sum     = {1'b0, vx} + {1'b0, vy};
      dt_tick = (s1_tick_ff && (dt_ff != 8'd0)) ? dt_ff - 8'd1 : dt_ff;
      st_tick = (s1_tick_ff && (st_ff != 8'd0)) ? st_ff - 8'd1 : st_ff;

      next_pc = pc2;
      wb      = '0;
      cls     = 1'b0;
      push    = 1'b0;
      status  = ST_OK;
      idx_in  = idx_ff;
      dt_in   = dt_tick;
      st_in   = st_tick;
      lvl_in  = lvl_ff;

      unique case (s1_op_ff[15:12])
         GRP_SYS: begin
            if (s1_op_ff == OPC_CLS) begin
               cls = 1'b1;
            end else if (s1_op_ff == OPC_RET) begin
               if (lvl_ff == '0) begin
                  status = ST_UNDERFLOW;
               end else begin
                  lvl_in  = lvl_ff - LVL_W'(1);
                  next_pc = stk_top;
               end
            end else begin
               status = ST_UNHANDLED;
            end
         end
         GRP_JP: next_pc = nnn;
         GRP_CALL: begin
            if (lvl_ff >= LVL_W'(STACK_DEPTH)) begin
               status = ST_OVERFLOW;
            end else begin
               push    = 1'b1;
               lvl_in  = lvl_ff + LVL_W'(1);
               next_pc = nnn;
            end
         end
         GRP_SE:  if (vx == nn) next_pc = pc4;
         GRP_SNE: if (vx != nn) next_pc = pc4;
         GRP_SER: begin
            if (n != 4'd0) status = ST_UNHANDLED;
            else if (vx == vy) next_pc = pc4;
         end
         GRP_LD: begin
            wb.wx = 1'b1; wb.x = x; wb.valx = nn;
         end
         GRP_ADD: begin
            wb.wx = 1'b1; wb.x = x; wb.valx = vx + nn;
         end
         GRP_ALU: begin
            wb.x = x;
            unique case (n)
               ALU_MOV: begin wb.wx = 1'b1; wb.valx = vy; end
               ALU_OR:  begin wb.wx = 1'b1; wb.valx = vx | vy; end
               ALU_AND: begin wb.wx = 1'b1; wb.valx = vx & vy; end
               ALU_XOR: begin wb.wx = 1'b1; wb.valx = vx ^ vy; end
               ALU_ADD: begin
                  wb.wx = 1'b1; wb.valx = sum[7:0];
                  wb.wf = 1'b1; wb.valf = sum[8];
               end
               ALU_SUB: begin
                  wb.wx = 1'b1; wb.valx = vx - vy;
                  wb.wf = 1'b1; wb.valf = (vx >= vy);
               end
               ALU_SHR: begin
                  wb.wx = 1'b1; wb.valx = {1'b0, vx[7:1]};
                  wb.wf = 1'b1; wb.valf = vx[0];
               end
               ALU_SUBN: begin
                  wb.wx = 1'b1; wb.valx = vy - vx;
                  wb.wf = 1'b1; wb.valf = (vy >= vx);
               end
               ALU_SHL: begin
                  wb.wx = 1'b1; wb.valx = {vx[6:0], 1'b0};
                  wb.wf = 1'b1; wb.valf = vx[7];
               end
               default: begin
                  wb.x   = 4'd0;
                  status = ST_UNHANDLED;
               end
            endcase
         end
         GRP_SNER: begin
            if (n != 4'd0) status = ST_UNHANDLED;
            else if (vx != vy) next_pc = pc4;
         end
         GRP_LDI:  idx_in = {4'd0, nnn};
         GRP_JPV0: next_pc = {4'd0, vx} + nnn;
         GRP_RND: begin
            wb.wx = 1'b1; wb.x = x; wb.valx = s1_rnd_ff & nn;
         end
         GRP_MISC: begin
            unique case (nn)
               FX_GET_DT: begin wb.wx = 1'b1; wb.x = x; wb.valx = dt_tick; end
               FX_SET_DT: dt_in = vx;
               FX_SET_ST: st_in = vx;
               FX_ADD_I:  idx_in = idx_ff + {8'd0, vx};
               // font starts at address zero, five bytes per glyph
               FX_FONT:   idx_in = {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
               default:   status = ST_UNHANDLED;
            endcase
         end
         default: status = ST_UNHANDLED;
      endcase
   end

   // stack read for the item accepted now sees the level after the commit
   assign lvl_cur = fire ? lvl_in : lvl_ff;
   assign lvl_rd  = lvl_cur - LVL_W'(1);

   always_ff @(posedge clock) begin
      if (fire && push) begin
         stack_mem[lvl_ff[SP_W-1:0]] <= pc2;
      end
      if (accept) begin
         stk_data_ff <= stack_mem[lvl_rd[SP_W-1:0]];
         stk_fwd_ff  <= pc2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= 12'h200;
         idx_ff       <= 16'h0200;
         lvl_ff       <= '0;
         dt_ff        <= '0;
         st_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         s1_op_ff     <= '0;
         s1_rnd_ff    <= '0;
         s1_tick_ff   <= 1'b0;
         stk_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         if (fire) begin
            pc_ff  <= next_pc;
            idx_ff <= idx_in;
            lvl_ff <= lvl_in;
            dt_ff  <= dt_in;
            st_ff  <= st_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            s1_op_ff    <= req_instruction_word;
            s1_rnd_ff   <= req_random_byte;
            s1_tick_ff  <= req_timer_tick;
            // a push on this edge lands in the slot the new item would read
            stk_hit_ff  <= fire && push;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            status_ff    <= status;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         next_pc_ff     <= next_pc;
         vx_write_ff    <= wb.wx;
         vx_index_ff    <= wb.wx ? wb.x : 4'd0;
         vx_value_ff    <= wb.wx ? wb.valx : 8'd0;
         vf_write_ff    <= wb.wf;
         vf_value_ff    <= wb.wf & wb.valf;
         index_value_ff <= idx_in;
         cls_ff         <= cls;
         sound_ff       <= (st_in != 8'd0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = next_pc_ff;
   assign rsp_vx_write     = vx_write_ff;
   assign rsp_vx_index     = vx_index_ff;
   assign rsp_vx_value     = vx_value_ff;
   assign rsp_vf_write     = vf_write_ff;
   assign rsp_vf_value     = vf_value_ff;
   assign rsp_index_value  = index_value_ff;
   assign rsp_clear_screen = cls_ff;
   assign rsp_sound_on     = sound_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

// ----- dv/tb_chip8_register_execute_unit_top.sv -----
`timescale 1ns / 100ps
// testbench for chip8_register_execute_unit_top: streams chip-8 opcodes
// through the unit and checks every result against an in-bench execution model
// depends on c8eu_pkg and the rtl of the unit

module tb_chip8_register_execute_unit_top;
   import c8eu_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;

   // sub-codes with no meaning to the unit
   localparam logic [3:0] ALU_NONE = 4'h8;
   localparam logic [7:0] FX_NONE  = 8'h33;
   localparam logic [3:0] GRP_DRAW = 4'hD;
   localparam logic [3:0] GRP_KEY  = 4'hE;

   typedef struct packed {
      logic [11:0] next_pc;
      logic        vx_write;
      logic [3:0]  vx_index;
      logic [7:0]  vx_value;
      logic        vf_write;
      logic        vf_value;
      logic [15:0] index_value;
      logic        clear_screen;
      logic        sound_on;
      status_type  status;
   } retire_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_instruction_word;
   logic [7:0]  req_random_byte;
   logic        req_timer_tick;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_next_pc;
   logic        rsp_vx_write;
   logic [3:0]  rsp_vx_index;
   logic [7:0]  rsp_vx_value;
   logic        rsp_vf_write;
   logic        rsp_vf_value;
   logic [15:0] rsp_index_value;
   logic        rsp_clear_screen;
   logic        rsp_sound_on;
   logic [1:0]  rsp_status;

   // execution model state
   logic [7:0]  v_regs [16];
   logic [15:0] i_reg;
   logic [11:0] pc_reg;
   logic [11:0] call_stack [STACK_DEPTH];
   int          call_depth;
   logic [7:0]  delay_cnt;
   logic [7:0]  sound_cnt;

   retire_type  retire_q [$];
   int          mismatches;
   int          cycle_count = 0;
   bit          req_gaps_on;
   bit          rsp_stalls_on;
   int          rsp_hold_cycles;

   chip8_register_execute_unit_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_instruction_word (req_instruction_word),
      .req_random_byte      (req_random_byte),
      .req_timer_tick       (req_timer_tick),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_vx_write         (rsp_vx_write),
      .rsp_vx_index         (rsp_vx_index),
      .rsp_vx_value         (rsp_vx_value),
      .rsp_vf_write         (rsp_vf_write),
      .rsp_vf_value         (rsp_vf_value),
      .rsp_index_value      (rsp_index_value),
      .rsp_clear_screen     (rsp_clear_screen),
      .rsp_sound_on         (rsp_sound_on),
      .rsp_status           (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // runs one opcode on the model and queues the result it retires
   task automatic execute_opcode(input logic [15:0] op, input logic [7:0] rnd,
                                 input logic tick);
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, valx;
      logic [11:0] nnn, pc_next;
      logic [8:0]  sum;
      logic        wx, wf, valf;
      retire_type  r;
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      nn = op[7:0];
      nnn = op[11:0];
      vx = v_regs[x];
      vy = v_regs[y];
      pc_next = pc_reg + 12'd2;
      wx = 1'b0;
      wf = 1'b0;
      valx = '0;
      valf = 1'b0;
      r = '0;
      r.status = ST_OK;
      if (tick) begin
         if (delay_cnt != 0) delay_cnt = delay_cnt - 8'd1;
         if (sound_cnt != 0) sound_cnt = sound_cnt - 8'd1;
      end
      case (op[15:12])
         GRP_SYS: begin
            if (op == OPC_CLS) begin
               r.clear_screen = 1'b1;
            end else if (op == OPC_RET) begin
               if (call_depth == 0) begin
                  r.status = ST_UNDERFLOW;
               end else begin
                  call_depth--;
                  pc_next = call_stack[call_depth];
               end
            end else begin
               r.status = ST_UNHANDLED;
            end
         end
         GRP_JP: pc_next = nnn;
         GRP_CALL: begin
            if (call_depth >= STACK_DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               call_stack[call_depth] = pc_next;
               call_depth++;
               pc_next = nnn;
            end
         end
         GRP_SE:  if (vx == nn) pc_next = pc_reg + 12'd4;
         GRP_SNE: if (vx != nn) pc_next = pc_reg + 12'd4;
         GRP_SER: begin
            if (n != 0) r.status = ST_UNHANDLED;
            else if (vx == vy) pc_next = pc_reg + 12'd4;
         end
         GRP_LD: begin
            wx = 1'b1;
            valx = nn;
         end
         GRP_ADD: begin
            wx = 1'b1;
            valx = vx + nn;
         end
         GRP_ALU: begin
            wx = 1'b1;
            case (n)
               ALU_MOV: valx = vy;
               ALU_OR:  valx = vx | vy;
               ALU_AND: valx = vx & vy;
               ALU_XOR: valx = vx ^ vy;
               ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  valx = sum[7:0];
                  wf = 1'b1;
                  valf = sum[8];
               end
               ALU_SUB: begin
                  valx = vx - vy;
                  wf = 1'b1;
                  valf = (vx >= vy);
               end
               ALU_SHR: begin
                  valx = vx >> 1;
                  wf = 1'b1;
                  valf = vx[0];
               end
               ALU_SUBN: begin
                  valx = vy - vx;
                  wf = 1'b1;
                  valf = (vy >= vx);
               end
               ALU_SHL: begin
                  valx = vx << 1;
                  wf = 1'b1;
                  valf = vx[7];
               end
               default: begin
                  wx = 1'b0;
                  r.status = ST_UNHANDLED;
               end
            endcase
         end
         GRP_SNER: begin
            if (n != 0) r.status = ST_UNHANDLED;
            else if (vx != vy) pc_next = pc_reg + 12'd4;
         end
         GRP_LDI:  i_reg = {4'h0, nnn};
         GRP_JPV0: pc_next = {4'h0, v_regs[0]} + nnn;
         GRP_RND: begin
            wx = 1'b1;
            valx = rnd & nn;
         end
         GRP_MISC: begin
            case (nn)
               FX_GET_DT: begin
                  wx = 1'b1;
                  valx = delay_cnt;
               end
               FX_SET_DT: delay_cnt = vx;
               FX_SET_ST: sound_cnt = vx;
               FX_ADD_I:  i_reg = i_reg + {8'h00, vx};
               FX_FONT:   i_reg = {12'h000, vx[3:0]} * 16'd5;
               default:   r.status = ST_UNHANDLED;
            endcase
         end
         default: r.status = ST_UNHANDLED;
      endcase
      // flag is written after vx so it wins when x is vf
      if (wx) begin
         v_regs[x] = valx;
         r.vx_write = 1'b1;
         r.vx_index = x;
         r.vx_value = valx;
      end
      if (wf) begin
         v_regs[VF_IDX] = {7'b0, valf};
         r.vf_write = 1'b1;
         r.vf_value = valf;
      end
      pc_reg = pc_next;
      r.next_pc = pc_next;
      r.index_value = i_reg;
      r.sound_on = (sound_cnt != 0);
      retire_q.insert(retire_q.size(), r);
   endtask

   // offers one item and returns at the edge that accepts it
   task automatic send_opcode(input logic [15:0] op, input logic [7:0] rnd,
                              input logic tick);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= op;
      req_random_byte <= rnd;
      req_timer_tick <= tick;
      do @(posedge clock); while (req_ready !== 1'b1);
      execute_opcode(op, rnd, tick);
   endtask

   task automatic pause_until_retired();
      req_valid <= 1'b0;
      while (retire_q.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed opcodes, with skips aimed at current register values
   function automatic logic [15:0] pick_opcode();
      logic [3:0]  x, y, sub;
      logic [7:0]  nn, fx;
      logic [11:0] nnn;
      int          roll;
      x = 4'($urandom_range(0, 15));
      y = 4'($urandom_range(0, 15));
      nn = 8'($urandom_range(0, 255));
      nnn = 12'($urandom_range(0, 4095));
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         if ($urandom_range(0, 1) != 0) nn = 8'($urandom_range(0, 7));
         return {GRP_LD, x, nn};
      end else if (roll < 30) begin
         return {GRP_ADD, x, nn};
      end else if (roll < 50) begin
         case ($urandom_range(0, 8))
            0: sub = ALU_MOV;
            1: sub = ALU_OR;
            2: sub = ALU_AND;
            3: sub = ALU_XOR;
            4: sub = ALU_ADD;
            5: sub = ALU_SUB;
            6: sub = ALU_SHR;
            7: sub = ALU_SUBN;
            default: sub = ALU_SHL;
         endcase
         return {GRP_ALU, x, y, sub};
      end else if (roll < 56) begin
         if ($urandom_range(0, 1) != 0) nn = v_regs[x];
         return {($urandom_range(0, 1) != 0) ? GRP_SE : GRP_SNE, x, nn};
      end else if (roll < 60) begin
         if ($urandom_range(0, 1) != 0) y = x;
         return {($urandom_range(0, 1) != 0) ? GRP_SER : GRP_SNER, x, y, 4'h0};
      end else if (roll < 65) begin
         return {GRP_LDI, nnn};
      end else if (roll < 68) begin
         return {GRP_JPV0, nnn};
      end else if (roll < 72) begin
         return {GRP_RND, x, nn};
      end else if (roll < 81) begin
         case ($urandom_range(0, 4))
            0: fx = FX_GET_DT;
            1: fx = FX_SET_DT;
            2: fx = FX_SET_ST;
            3: fx = FX_ADD_I;
            default: fx = FX_FONT;
         endcase
         return {GRP_MISC, x, fx};
      end else if (roll < 87) begin
         return {GRP_CALL, nnn};
      end else if (roll < 93) begin
         return OPC_RET;
      end else if (roll < 95) begin
         return ($urandom_range(0, 1) != 0) ? {GRP_JP, nnn} : OPC_CLS;
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic test_directed_ops();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      send_opcode(OPC_CLS, 8'h00, 1'b0);
      send_opcode(OPC_RET, 8'h00, 1'b0);
      send_opcode({GRP_SYS, 12'h123}, 8'h00, 1'b0);
      send_opcode({GRP_LD, 4'h0, 8'hFF}, 8'h00, 1'b0);
      send_opcode({GRP_LD, 4'h1, 8'h01}, 8'h00, 1'b0);
      send_opcode({GRP_ADD, 4'h1, 8'h01}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_ADD}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_SUB}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_SHR}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_SHL}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h1, 4'h0, ALU_SUBN}, 8'h00, 1'b0);
      // destination is vf itself, flag must win
      send_opcode({GRP_ALU, VF_IDX, 4'h0, ALU_ADD}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_XOR}, 8'h00, 1'b0);
      send_opcode({GRP_ALU, 4'h0, 4'h1, ALU_NONE}, 8'h00, 1'b0);
      send_opcode({GRP_SER, 4'h0, 4'h1, 4'h1}, 8'h00, 1'b0);
      send_opcode({GRP_SNER, 4'h0, 4'h1, 4'h0}, 8'h00, 1'b0);
      send_opcode({GRP_SE, 4'h0, v_regs[0]}, 8'h00, 1'b0);
      send_opcode({GRP_SNE, 4'h0, v_regs[0]}, 8'h00, 1'b0);
      send_opcode({GRP_RND, 4'h3, 8'hA5}, 8'hFF, 1'b0);
      send_opcode({GRP_MISC, 4'h3, FX_FONT}, 8'h00, 1'b0);
      send_opcode({GRP_DRAW, 12'h123}, 8'h00, 1'b0);
      send_opcode({GRP_KEY, 4'h1, 8'h9E}, 8'h00, 1'b0);
      send_opcode({GRP_MISC, 4'h3, FX_NONE}, 8'h00, 1'b0);
      send_opcode({GRP_JPV0, 12'hFFF}, 8'h00, 1'b0);
      // taken skip at the top of memory wraps the address
      send_opcode({GRP_JP, 12'hFFE}, 8'h00, 1'b0);
      send_opcode({GRP_SER, 4'h2, 4'h2, 4'h0}, 8'h00, 1'b0);
   endtask

   task automatic test_timers();
      int k;
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      send_opcode({GRP_LD, 4'hA, 8'h03}, 8'h00, 1'b0);
      send_opcode({GRP_MISC, 4'hA, FX_SET_DT}, 8'h00, 1'b0);
      send_opcode({GRP_MISC, 4'hA, FX_SET_ST}, 8'h00, 1'b0);
      for (k = 0; k < 5; k++) send_opcode({GRP_MISC, 4'hB, FX_GET_DT}, 8'h00, 1'b1);
      send_opcode({GRP_LD, 4'hA, 8'hFF}, 8'h00, 1'b1);
      send_opcode({GRP_MISC, 4'hA, FX_SET_ST}, 8'h00, 1'b1);
      send_opcode({GRP_MISC, 4'hC, FX_GET_DT}, 8'h00, 1'b1);
   endtask

   task automatic test_call_stack();
      int k;
      logic [11:0] nnn;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      // one call past a full stack, one return past an empty one
      for (k = 0; k <= STACK_DEPTH; k++) begin
         nnn = 12'($urandom_range(0, 4095));
         send_opcode({GRP_CALL, nnn}, 8'h00, 1'b0);
      end
      for (k = 0; k <= STACK_DEPTH; k++) send_opcode(OPC_RET, 8'h00, 1'b0);
   endtask

   task automatic test_index_wrap();
      int k;
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b1;
      send_opcode({GRP_LD, 4'h5, 8'hFF}, 8'h00, 1'b0);
      send_opcode({GRP_LDI, 12'hFFF}, 8'h00, 1'b0);
      for (k = 0; k < 241; k++) send_opcode({GRP_MISC, 4'h5, FX_ADD_I}, 8'h00, 1'b0);
      send_opcode({GRP_MISC, 4'h5, FX_FONT}, 8'h00, 1'b0);
   endtask

   task automatic test_input_backpressure();
      int k;
      pause_until_retired();
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_cycles = 80;
      for (k = 0; k < 40; k++)
         send_opcode(pick_opcode(), 8'($urandom_range(0, 255)), 1'b0);
      pause_until_retired();
   endtask

   task automatic test_random_programs();
      int phase, k;
      for (phase = 0; phase < 8; phase++) begin
         req_gaps_on = (phase != 0) && ($urandom_range(0, 2) != 0);
         rsp_stalls_on = (phase != 0) && ($urandom_range(0, 2) != 0);
         for (k = 0; k < 155; k++)
            send_opcode(pick_opcode(), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 3) == 0);
         pause_until_retired();
      end
   endtask

   initial begin
      int k;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_instruction_word <= '0;
      req_random_byte <= '0;
      req_timer_tick <= 1'b0;
      mismatches = 0;
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_cycles = 0;
      for (k = 0; k < 16; k++) v_regs[k] = '0;
      for (k = 0; k < STACK_DEPTH; k++) call_stack[k] = '0;
      i_reg = 16'h0200;
      pc_reg = 12'h200;
      call_depth = 0;
      delay_cnt = '0;
      sound_cnt = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_timers();
      test_call_stack();
      test_index_wrap();
      test_input_backpressure();
      test_random_programs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && retire_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // result side: random stalls per item, plus the long hold when asked
   initial begin : result_sink
      int stall;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_stalls_on ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : retire_check
      retire_type seen, want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen = {rsp_next_pc, rsp_vx_write, rsp_vx_index, rsp_vx_value, rsp_vf_write,
                 rsp_vf_value, rsp_index_value, rsp_clear_screen, rsp_sound_on, rsp_status};
         if (retire_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: pc=%h status=%0d", rsp_next_pc, rsp_status);
         end else begin
            want = retire_q.pop_front();
            if (seen.next_pc !== want.next_pc || seen.vx_write !== want.vx_write ||
                seen.vx_index !== want.vx_index || seen.vx_value !== want.vx_value ||
                seen.vf_write !== want.vf_write || seen.vf_value !== want.vf_value ||
                seen.index_value !== want.index_value ||
                seen.clear_screen !== want.clear_screen ||
                seen.sound_on !== want.sound_on || seen.status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result mismatch at %0t", $time);
                  $display("  exp pc=%h vx=%b/%h/%h vf=%b/%b i=%h cls=%b snd=%b st=%0d",
                           want.next_pc, want.vx_write, want.vx_index, want.vx_value,
                           want.vf_write, want.vf_value, want.index_value,
                           want.clear_screen, want.sound_on, want.status);
                  $display("  got pc=%h vx=%b/%h/%h vf=%b/%b i=%h cls=%b snd=%b st=%0d",
                           seen.next_pc, seen.vx_write, seen.vx_index, seen.vx_value,
                           seen.vf_write, seen.vf_value, seen.index_value,
                           seen.clear_screen, seen.sound_on, seen.status);
               end
            end
         end
      end
   end

endmodule
